>>> hdl/lru_pkg.sv
// lru_pkg: shared types, request codes and sizes for the lru cache with ttl
// revalidation; no dependencies
package lru_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int QDEPTH = 2;
  localparam int QP_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    req_t        req;
    logic [63:0] key;
    logic [63:0] iv_low;
    logic [63:0] iv_high;
    logic [63:0] wtime;
    logic [63:0] now;
    logic [63:0] ftime;
    logic        ftime_ok;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] lo;
    logic [63:0] hi;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;
endpackage

>>> hdl/lru_front.sv
// lru_front: input stage and short item queue toward the back part
// depends on lru_pkg
module lru_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lru_pkg::item_t    in_item,
  output logic              q_valid,
  input  logic              q_ready,
  output lru_pkg::item_t    q_item
);
  import lru_pkg::*;

  item_t mem_r [QDEPTH];
  logic [QP_W-1:0] wp_r, rp_r;
  logic [QC_W-1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != QC_W'(QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      // unknown request code travels as no-op
      mem_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == QP_W'(QDEPTH - 1)) ? '0 : wp_r + QP_W'(1);
      if (pop) rp_r <= (rp_r == QP_W'(QDEPTH - 1)) ? '0 : rp_r + QP_W'(1);
      cnt_r <= cnt_r + QC_W'(push) - QC_W'(pop);
    end
  end

  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QC_W'(QDEPTH)) else $error("queue overflow");
  a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !q_valid) else $error("pop from empty");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop && cnt_r == '0 |=> cnt_r == QC_W'(1)) else $error("count slip");
endmodule

>>> hdl/lru_back.sv
// lru_back: executes lookup, store and remove against the entry table
// depends on lru_pkg
module lru_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       ttl,
  input  logic              q_valid,
  output logic              q_ready,
  input  lru_pkg::item_t    q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output lru_pkg::res_t     res
);
  import lru_pkg::*;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [IDX_W-1:0]   rank_nxt [ENTRIES];
  logic [63:0] key_r [ENTRIES];
  logic [63:0] lo_r [ENTRIES];
  logic [63:0] hi_r [ENTRIES];
  logic [63:0] stamp_r [ENTRIES];
  logic [63:0] wt_r [ENTRIES];

  state_t state_r, state_nxt;
  item_t  it_r;
  res_t   res_r, res_nxt;
  logic [IDX_W-1:0] hidx_r, fidx_r, vidx_r;
  logic hfound_r, ffound_r, full_r;
  // matched entry contents, read at capture
  logic [63:0] rlo_r, rhi_r, rstamp_r, rwt_r;

  // match search result (combinational, registered at capture)
  logic [IDX_W-1:0] hidx, fidx, vidx;
  logic hfound, ffound;

  always_comb begin
    hidx = '0; hfound = 1'b0; fidx = '0; ffound = 1'b0; vidx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == q_item.key) begin
        hidx = IDX_W'(i); hfound = 1'b1;
      end
      if (!valid_r[i]) begin
        fidx = IDX_W'(i); ffound = 1'b1;
      end
      if (rank_r[i] == IDX_W'(ENTRIES - 1)) vidx = IDX_W'(i);
    end
  end

  logic [63:0] age;
  logic fresh, reval;
  logic [IDX_W-1:0] e, r;
  logic wr_en, stamp_only;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    rank_nxt = rank_r;
    res_nxt = res_r;
    q_ready = 1'b0;
    wr_en = 1'b0;
    stamp_only = 1'b0;
    age = it_r.now - rstamp_r;
    fresh = (ttl == 32'd0) || (age < {32'd0, ttl});
    reval = it_r.ftime_ok && (rwt_r >= it_r.ftime);
    e = hidx_r;
    r = rank_r[hidx_r];
    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        res_nxt = '0;
        state_nxt = ST_OUT;
        case (it_r.req)
          REQ_LOOKUP: begin
            if (hfound_r) begin
              if (fresh || reval) begin
                stamp_only = !fresh;
                res_nxt.hit = 1'b1;
                res_nxt.lo = rlo_r;
                res_nxt.hi = rhi_r;
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i] && rank_r[i] < r) rank_nxt[i] = rank_r[i] + 1'b1;
                rank_nxt[hidx_r] = '0;
              end else begin
                valid_nxt[hidx_r] = 1'b0;
                rank_nxt[hidx_r] = '0;
                for (int i = 0; i < ENTRIES; i++)
                  if (valid_r[i] && rank_r[i] > r) rank_nxt[i] = rank_r[i] - 1'b1;
              end
            end
          end
          REQ_STORE: begin
            wr_en = 1'b1;
            if (hfound_r) begin
              for (int i = 0; i < ENTRIES; i++)
                if (valid_r[i] && rank_r[i] < r) rank_nxt[i] = rank_r[i] + 1'b1;
              rank_nxt[hidx_r] = '0;
            end else begin
              // full: victim holds top rank, everyone else ages by one anyway
              e = full_r ? vidx_r : fidx_r;
              for (int i = 0; i < ENTRIES; i++)
                if (valid_r[i]) rank_nxt[i] = rank_r[i] + 1'b1;
              valid_nxt[e] = 1'b1;
              rank_nxt[e] = '0;
            end
          end
          REQ_REMOVE: begin
            if (hfound_r) begin
              valid_nxt[hidx_r] = 1'b0;
              rank_nxt[hidx_r] = '0;
              for (int i = 0; i < ENTRIES; i++)
                if (valid_r[i] && rank_r[i] > r) rank_nxt[i] = rank_r[i] - 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res_valid = (state_r == ST_OUT);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      it_r <= q_item;
      hidx_r <= hidx; hfound_r <= hfound;
      fidx_r <= fidx; ffound_r <= ffound;
      vidx_r <= vidx; full_r <= !ffound;
      rlo_r <= lo_r[hidx];
      rhi_r <= hi_r[hidx];
      rstamp_r <= stamp_r[hidx];
      rwt_r <= wt_r[hidx];
    end
    res_r <= res_nxt;
    if (wr_en) begin
      key_r[e] <= it_r.key;
      lo_r[e] <= it_r.iv_low;
      hi_r[e] <= it_r.iv_high;
      wt_r[e] <= it_r.wtime;
      stamp_r[e] <= it_r.now;
    end else if (stamp_only) begin
      stamp_r[hidx_r] <= it_r.now;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      rank_r <= rank_nxt;
    end
  end

  a_ffound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> ffound_r == !full_r) else $error("free flag slip");
  a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.hit |-> it_r.req == REQ_LOOKUP) else $error("hit on non-lookup");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result lost");
endmodule

>>> hdl/lru_cache_with_ttl_revalidation.sv
// lru_cache_with_ttl_revalidation: top level, front queue plus execution back part
// depends on lru_pkg, lru_front, lru_back
// path: an accepted item passes the queue, then capture and execute in the back part,
// before its result is valid
// the back part takes a new item only after its previous result is accepted, through its
// capture/execute/output sequence; the 2-entry queue keeps accepting while a result waits
// reset (rst_n low, synchronous): all entries invalid, ranks zero, ttl zero,
// queue empty; no clearing pass is needed
module lru_cache_with_ttl_revalidation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,     // ttl_ms
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,      // req_type
  // key_tag, iv_low, iv_high, write_time, now_ms, file_time, file_time_ok, 7 zero pad
  input  logic [391:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,     // hit
  output logic [127:0] out_tdata      // out_iv_low, out_iv_high
);
  import lru_pkg::*;

  logic [31:0] ttl_r;
  item_t in_item, q_item;
  logic q_valid, q_ready;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) ttl_r <= '0;
    else if (cfg_we) ttl_r <= cfg_wdata;
  end

  always_comb begin
    in_item.req = req_t'(in_tuser);
    in_item.key = in_tdata[63:0];
    in_item.iv_low = in_tdata[127:64];
    in_item.iv_high = in_tdata[191:128];
    in_item.wtime = in_tdata[255:192];
    in_item.now = in_tdata[319:256];
    in_item.ftime = in_tdata[383:320];
    in_item.ftime_ok = in_tdata[384];
  end

  lru_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  lru_back u_back (
    .clk, .rst_n, .ttl(ttl_r),
    .q_valid, .q_ready, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tuser = res.hit;
  assign out_tdata = {res.hi, res.lo};

  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0) else $error("miss data nonzero");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> ttl_r == $past(cfg_wdata)) else $error("ttl write lost");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(in_tready) || $past(!in_tready) ) else $error("ready check");
endmodule
